>>> rtl/clul_pkg.sv
// ---------------------------------------------------------------------------
// clul_pkg
// shared types and codes for the circular list insert/remove unit
// ---------------------------------------------------------------------------
package clul_pkg;

    // operation code of an input transfer
    typedef enum logic [1:0] {
        KIND_ADD_FRONT = 2'd0,
        KIND_ADD_BACK  = 2'd1,
        KIND_REMOVE    = 2'd2,
        KIND_NONE      = 2'd3
    } t_kind;

    // status code of a result transfer
    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_EMPTY     = 2'd3
    } t_status;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_A,
        S_INS_B,
        S_WALK,
        S_RELINK,
        S_FIXV,
        S_RESP
    } t_state;

    // write enables of the link tables
    typedef struct packed {
        logic val;
        logic nxt;
        logic prv;
    } t_ram_we;

    // free pool requests
    typedef struct packed {
        logic alloc;
        logic release_slot;
    } t_pool_ctl;

endpackage

>>> rtl/circular_list_insert_remove_unit.sv
// ---------------------------------------------------------------------------
// circular_list_insert_remove_unit
// bounded circular doubly linked list with add front, add back and
// remove first matching value
// ---------------------------------------------------------------------------
// usage
//   input channel: i_in_valid / o_in_stall carry kind and value; a transfer
//   takes place when valid is high and stall is low
//   output channel: o_out_valid / i_out_stall carry status, count, empty
//   flag and the head and tail values after the operation
//   one result per input transfer, in order
// timing
//   one item at a time; o_in_stall is high from the accepting edge until the
//   result is loaded into the output register
//   add: an empty list passes S_INS_A, others S_INS_A and S_INS_B; a full list
//   goes straight to S_RESP; remove: walks from the head (the value table read
//   port moves one link per cycle); with entries left, S_RELINK and S_FIXV relink
//   and refetch the end value; an empty list or unused kind goes straight to S_RESP
//   the next item can be taken while the result still waits in the output
//   register
// reset
//   synchronous, active low; list empty, no clearing pass is needed
// stall
//   a stalled result holds; a finished operation waits in its response
//   state until the output register is free
// ---------------------------------------------------------------------------
module circular_list_insert_remove_unit #(
    parameter int CAPACITY   = 16,
    parameter int VALUE_BITS = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // input channel
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [1:0]                   i_in_kind,
    input  logic signed [VALUE_BITS-1:0] i_in_value,
    // output channel
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [1:0]                   o_out_status,
    output logic [$clog2(CAPACITY+1)-1:0] o_out_count,
    output logic                         o_out_is_empty,
    output logic signed [VALUE_BITS-1:0] o_out_first_value,
    output logic signed [VALUE_BITS-1:0] o_out_last_value
);
    import clul_pkg::*;

    localparam int SLOT_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W  = $clog2(CAPACITY + 1);

    // sequencer and list registers
    t_state                r_state, n_state;
    t_kind                 r_kind, n_kind;
    t_status               r_status, n_status;
    logic [VALUE_BITS-1:0] r_value, n_value;
    logic [CNT_W-1:0]      r_count, n_count;
    logic [CNT_W-1:0]      r_idx, n_idx;
    logic [SLOT_W-1:0]     r_head, n_head;
    logic [SLOT_W-1:0]     r_tail, n_tail;
    logic [VALUE_BITS-1:0] r_head_val, n_head_val;
    logic [VALUE_BITS-1:0] r_tail_val, n_tail_val;
    logic [SLOT_W-1:0]     r_cur, n_cur;
    logic [SLOT_W-1:0]     r_slot, n_slot;
    logic                  r_fix_head, n_fix_head;
    logic                  r_fix_tail, n_fix_tail;

    // output register
    logic                  r_out_valid, n_out_valid;
    t_status               r_out_status, n_out_status;
    logic [CNT_W-1:0]      r_out_count, n_out_count;
    logic                  r_out_empty, n_out_empty;
    logic [VALUE_BITS-1:0] r_out_first, n_out_first;
    logic [VALUE_BITS-1:0] r_out_last, n_out_last;

    // table and pool interfaces
    t_ram_we               ram_we;
    logic [SLOT_W-1:0]     rd_addr;
    logic [SLOT_W-1:0]     val_addr, nxt_addr, nxt_data, prv_addr, prv_data;
    logic [VALUE_BITS-1:0] val_q;
    logic [SLOT_W-1:0]     nxt_q, prv_q;
    t_pool_ctl             pool_ctl;
    logic [SLOT_W-1:0]     release_slot;
    logic [SLOT_W-1:0]     alloc_slot;

    logic                  in_xfer;
    logic                  out_free;
    logic                  match;

    clul_link_ram #(
        .CAPACITY  (CAPACITY),
        .VALUE_BITS(VALUE_BITS),
        .SLOT_W    (SLOT_W)
    ) u_link_ram (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_rd_addr (rd_addr),
        .i_val_addr(val_addr),
        .i_val_data(r_value),
        .i_nxt_addr(nxt_addr),
        .i_nxt_data(nxt_data),
        .i_prv_addr(prv_addr),
        .i_prv_data(prv_data),
        .o_val_q   (val_q),
        .o_nxt_q   (nxt_q),
        .o_prv_q   (prv_q)
    );

    clul_free_pool #(
        .CAPACITY(CAPACITY),
        .SLOT_W  (SLOT_W),
        .CNT_W   (CNT_W)
    ) u_free_pool (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (pool_ctl),
        .i_release_slot(release_slot),
        .o_alloc_slot  (alloc_slot)
    );

    assign o_in_stall = (r_state != S_IDLE);
    assign in_xfer    = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;
    // the one wide comparator, reused for every walked entry
    assign match      = (val_q == r_value);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_head      <= '0;
            r_tail      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        r_kind       <= n_kind;
        r_status     <= n_status;
        r_value      <= n_value;
        r_idx        <= n_idx;
        r_head_val   <= n_head_val;
        r_tail_val   <= n_tail_val;
        r_cur        <= n_cur;
        r_slot       <= n_slot;
        r_fix_head   <= n_fix_head;
        r_fix_tail   <= n_fix_tail;
        r_out_status <= n_out_status;
        r_out_count  <= n_out_count;
        r_out_empty  <= n_out_empty;
        r_out_first  <= n_out_first;
        r_out_last   <= n_out_last;
    end

    always_comb begin
        n_state      = r_state;
        n_kind       = r_kind;
        n_status     = r_status;
        n_value      = r_value;
        n_count      = r_count;
        n_idx        = r_idx;
        n_head       = r_head;
        n_tail       = r_tail;
        n_head_val   = r_head_val;
        n_tail_val   = r_tail_val;
        n_cur        = r_cur;
        n_slot       = r_slot;
        n_fix_head   = r_fix_head;
        n_fix_tail   = r_fix_tail;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out_status = r_out_status;
        n_out_count  = r_out_count;
        n_out_empty  = r_out_empty;
        n_out_first  = r_out_first;
        n_out_last   = r_out_last;

        ram_we       = '0;
        rd_addr      = r_cur;
        val_addr     = r_slot;
        nxt_addr     = r_slot;
        nxt_data     = r_slot;
        prv_addr     = r_slot;
        prv_data     = r_slot;
        pool_ctl     = '0;
        release_slot = r_cur;

        unique case (r_state)
            S_IDLE: begin
                // head entry is fetched ahead so a walk starts at once
                rd_addr = r_head;
                if (in_xfer) begin
                    n_kind  = t_kind'(i_in_kind);
                    n_value = i_in_value;
                    unique case (t_kind'(i_in_kind))
                        KIND_ADD_FRONT, KIND_ADD_BACK: begin
                            if (r_count == CNT_W'(CAPACITY)) begin
                                n_status = ST_FULL;
                                n_state  = S_RESP;
                            end else begin
                                n_state = S_INS_A;
                            end
                        end
                        KIND_REMOVE: begin
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                                n_state  = S_RESP;
                            end else begin
                                n_cur   = r_head;
                                n_idx   = '0;
                                n_state = S_WALK;
                            end
                        end
                        default: begin
                            n_status = ST_DONE;
                            n_state  = S_RESP;
                        end
                    endcase
                end
            end

            S_INS_A: begin
                // new slot points to itself or closes the ring at both ends
                pool_ctl.alloc = 1'b1;
                n_slot         = alloc_slot;
                ram_we         = '{val: 1'b1, nxt: 1'b1, prv: 1'b1};
                val_addr       = alloc_slot;
                nxt_addr       = alloc_slot;
                prv_addr       = alloc_slot;
                if (r_count == '0) begin
                    nxt_data   = alloc_slot;
                    prv_data   = alloc_slot;
                    n_head     = alloc_slot;
                    n_tail     = alloc_slot;
                    n_head_val = r_value;
                    n_tail_val = r_value;
                    n_count    = r_count + 1'b1;
                    n_status   = ST_DONE;
                    n_state    = S_RESP;
                end else begin
                    nxt_data = r_head;
                    prv_data = r_tail;
                    n_state  = S_INS_B;
                end
            end

            S_INS_B: begin
                // old tail and old head now point at the new slot
                ram_we   = '{val: 1'b0, nxt: 1'b1, prv: 1'b1};
                nxt_addr = r_tail;
                nxt_data = r_slot;
                prv_addr = r_head;
                prv_data = r_slot;
                if (r_kind == KIND_ADD_FRONT) begin
                    n_head     = r_slot;
                    n_head_val = r_value;
                end else begin
                    n_tail     = r_slot;
                    n_tail_val = r_value;
                end
                n_count  = r_count + 1'b1;
                n_status = ST_DONE;
                n_state  = S_RESP;
            end

            S_WALK: begin
                // entry at r_cur is on the read port; on a mismatch fetch its successor, on a match hold it
                if (match) begin
                    rd_addr = r_cur;
                    if (r_count == CNT_W'(1)) begin
                        pool_ctl.release_slot = 1'b1;
                        n_count  = '0;
                        n_head   = '0;
                        n_tail   = '0;
                        n_status = ST_DONE;
                        n_state  = S_RESP;
                    end else begin
                        n_state = S_RELINK;
                    end
                end else begin
                    rd_addr = nxt_q;
                    if (r_idx == CNT_W'(r_count - 1'b1)) begin
                        n_status = ST_NOT_FOUND;
                        n_state  = S_RESP;
                    end else begin
                        n_cur = nxt_q;
                        n_idx = r_idx + 1'b1;
                    end
                end
            end

            S_RELINK: begin
                // bridge predecessor and successor, free the slot
                ram_we   = '{val: 1'b0, nxt: 1'b1, prv: 1'b1};
                nxt_addr = prv_q;
                nxt_data = nxt_q;
                prv_addr = nxt_q;
                prv_data = prv_q;
                pool_ctl.release_slot = 1'b1;
                n_fix_head = (r_cur == r_head);
                n_fix_tail = (r_cur == r_tail);
                rd_addr    = (r_cur == r_head) ? nxt_q : prv_q;
                if (r_cur == r_head) begin
                    n_head = nxt_q;
                end
                if (r_cur == r_tail) begin
                    n_tail = prv_q;
                end
                n_count  = r_count - 1'b1;
                n_status = ST_DONE;
                n_state  = S_FIXV;
            end

            S_FIXV: begin
                // new end value arrives from the value table
                if (r_fix_head) begin
                    n_head_val = val_q;
                end
                if (r_fix_tail) begin
                    n_tail_val = val_q;
                end
                n_state = S_RESP;
            end

            S_RESP: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_count  = r_count;
                    n_out_empty  = (r_count == '0);
                    n_out_first  = (r_count == '0) ? '0 : r_head_val;
                    n_out_last   = (r_count == '0) ? '0 : r_tail_val;
                    n_state      = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_out_valid       = r_out_valid;
    assign o_out_status      = r_out_status;
    assign o_out_count       = r_out_count;
    assign o_out_is_empty    = r_out_empty;
    assign o_out_first_value = r_out_first;
    assign o_out_last_value  = r_out_last;

    // list never holds more than its capacity
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    // walk index stays inside the list
    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> (r_idx < r_count))
        else $error("walk ran past the last entry");

    // empty flag agrees with the reported count
    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_is_empty == (o_out_count == '0)))
        else $error("empty flag disagrees with count");

    // an accepted transfer always starts the sequencer
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> (r_state != S_IDLE))
        else $error("sequencer idle after accepted transfer");

endmodule

>>> rtl/clul_link_ram.sv
// ---------------------------------------------------------------------------
// clul_link_ram
// value, successor and predecessor tables, one write and one registered
// read per table and cycle, all read at one shared address
// ---------------------------------------------------------------------------
module clul_link_ram #(
    parameter int CAPACITY   = 16,
    parameter int VALUE_BITS = 32,
    parameter int SLOT_W     = 4
) (
    input  logic                  i_clk,
    input  clul_pkg::t_ram_we     i_we,
    input  logic [SLOT_W-1:0]     i_rd_addr,
    input  logic [SLOT_W-1:0]     i_val_addr,
    input  logic [VALUE_BITS-1:0] i_val_data,
    input  logic [SLOT_W-1:0]     i_nxt_addr,
    input  logic [SLOT_W-1:0]     i_nxt_data,
    input  logic [SLOT_W-1:0]     i_prv_addr,
    input  logic [SLOT_W-1:0]     i_prv_data,
    output logic [VALUE_BITS-1:0] o_val_q,
    output logic [SLOT_W-1:0]     o_nxt_q,
    output logic [SLOT_W-1:0]     o_prv_q
);
    import clul_pkg::*;

    logic [VALUE_BITS-1:0] r_val_mem [CAPACITY];
    logic [SLOT_W-1:0]     r_nxt_mem [CAPACITY];
    logic [SLOT_W-1:0]     r_prv_mem [CAPACITY];

    always_ff @(posedge i_clk) begin
        if (i_we.val) begin
            r_val_mem[i_val_addr] <= i_val_data;
        end
        o_val_q <= r_val_mem[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_we.nxt) begin
            r_nxt_mem[i_nxt_addr] <= i_nxt_data;
        end
        o_nxt_q <= r_nxt_mem[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_we.prv) begin
            r_prv_mem[i_prv_addr] <= i_prv_data;
        end
        o_prv_q <= r_prv_mem[i_rd_addr];
    end

endmodule

>>> rtl/clul_free_pool.sv
// ---------------------------------------------------------------------------
// clul_free_pool
// slot allocator: never used slots come from a fill counter, released
// slots go on a stack memory and are handed out again first
// ---------------------------------------------------------------------------
module clul_free_pool #(
    parameter int CAPACITY = 16,
    parameter int SLOT_W   = 4,
    parameter int CNT_W    = 5
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  clul_pkg::t_pool_ctl i_ctl,
    input  logic [SLOT_W-1:0]   i_release_slot,
    output logic [SLOT_W-1:0]   o_alloc_slot
);
    import clul_pkg::*;

    logic [SLOT_W-1:0] r_stack [CAPACITY];
    logic [SLOT_W-1:0] r_top_q;
    logic [CNT_W-1:0]  r_sp;
    logic [CNT_W-1:0]  r_fill;
    logic [SLOT_W-1:0] top_addr;

    assign top_addr = SLOT_W'(r_sp - 1'b1);

    // stack memory, top entry read every cycle
    always_ff @(posedge i_clk) begin
        if (i_ctl.release_slot) begin
            r_stack[r_sp[SLOT_W-1:0]] <= i_release_slot;
        end
        r_top_q <= r_stack[top_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp   <= '0;
            r_fill <= '0;
        end else if (i_ctl.release_slot) begin
            r_sp <= r_sp + 1'b1;
        end else if (i_ctl.alloc) begin
            if (r_sp != '0) begin
                r_sp <= r_sp - 1'b1;
            end else begin
                r_fill <= r_fill + 1'b1;
            end
        end
    end

    assign o_alloc_slot = (r_sp != '0) ? r_top_q : r_fill[SLOT_W-1:0];

endmodule
